// File: rtl/fba_pkg.sv
// shared types and constants for the fifo bus arbiter with acknowledge timeout
// used by fba_ctrl, fba_dp and fifo_bus_arbiter_ack_timeout; depends on nothing

package fba_pkg;

   localparam int QUEUE_DEPTH_DEF = 8;
   localparam logic [3:0] TIMEOUT_RESET = 4'd3;

   // input beat kinds
   typedef enum logic [1:0] {
      KIND_REQ  = 2'd0,
      KIND_ACK  = 2'd1,
      KIND_DATA = 2'd2,
      KIND_TICK = 2'd3
   } fba_kind_type;

   // result event codes
   typedef enum logic [2:0] {
      EV_SREQ = 3'd0,
      EV_MACK = 3'd1,
      EV_DATA = 3'd2,
      EV_END  = 3'd3,
      EV_DROP = 3'd4
   } fba_event_type;

   // bus phase of the arbiter
   typedef enum logic [3:0] {
      PH_IDLE   = 4'b0001,
      PH_WAIT   = 4'b0010,
      PH_REPORT = 4'b0100,
      PH_XFER   = 4'b1000
   } fba_phase_type;

   typedef struct packed {
      logic [3:0]  master_id;
      logic        read_not_write;
      logic [31:0] address;
      logic [7:0]  length;
   } fba_req_type;

   localparam int REQ_W = $bits(fba_req_type);

   // controller to datapath
   typedef struct packed {
      logic          capture;
      logic          push;
      logic          ack_seen;
      logic          tick_wait;
      logic          word_step;
      logic          report_done;
      logic          bus_free;
      logic          head_read;
      logic          grant;
      logic          emit;
      fba_event_type ev;
      logic          last;
   } fba_cmd_type;

   // datapath to controller
   typedef struct packed {
      fba_kind_type  kind;
      fba_phase_type phase;
      logic          full;
      logic          nonempty;
      logic          word_end;
      logic          responded;
   } fba_status_type;

endpackage

// File: rtl/fifo_bus_arbiter_ack_timeout.sv
// top level of the fifo bus arbiter with slave acknowledge timeout
// depends on fba_pkg, fba_ctrl, fba_dp (which holds the fba_ram queue)
//
// channel   ports                          handshake
// -------   ----------------------------   -----------------------------------
// request   start, busy, req_*             beat taken when start && !busy
// response  rsp_valid, rsp_*               one-cycle strobe, no back-pressure
// config    csr_we, csr_wdata              timeout register written when csr_we
//
// one beat is handled at a time; busy stays high from the edge that takes a beat
// until its last result is registered: a beat with at most one result is decoded in
// exec, a grant adds a registered queue ram read (read, then grant), and a final data
// word that ends a transfer and grants the next adds end before read and grant.
// each result appears on the rsp_ ports one cycle after it is formed, at most one per
// cycle, and the beat after may be taken in the cycle its last result is shown.
// reset is synchronous; it empties the queue, idles the bus and sets the timeout to 3

module fifo_bus_arbiter_ack_timeout #(
   parameter int QUEUE_DEPTH = fba_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [3:0]  req_master_id,
   input  logic        req_read_not_write,
   input  logic [31:0] req_address,
   input  logic [7:0]  req_length,
   input  logic [31:0] req_word_data,
   // response channel
   output logic        rsp_valid,
   output logic [2:0]  rsp_event_res,
   output logic [3:0]  rsp_out_master_id,
   output logic        rsp_out_read_not_write,
   output logic [31:0] rsp_out_address,
   output logic [7:0]  rsp_out_length,
   output logic        rsp_responded,
   output logic [31:0] rsp_out_data,
   output logic        rsp_last,
   // timeout register
   input  logic        csr_we,
   input  logic [3:0]  csr_wdata
);

   fba_pkg::fba_cmd_type    cmd;
   fba_pkg::fba_status_type status;

   // sequencer: decodes the captured beat against the bus phase
   fba_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   // queue, bus phase, counters and the result register
   fba_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .req_kind               (req_kind),
      .req_master_id          (req_master_id),
      .req_read_not_write     (req_read_not_write),
      .req_address            (req_address),
      .req_length             (req_length),
      .req_word_data          (req_word_data),
      .csr_we                 (csr_we),
      .csr_wdata              (csr_wdata),
      .cmd                    (cmd),
      .status                 (status),
      .rsp_valid              (rsp_valid),
      .rsp_event_res          (rsp_event_res),
      .rsp_out_master_id      (rsp_out_master_id),
      .rsp_out_read_not_write (rsp_out_read_not_write),
      .rsp_out_address        (rsp_out_address),
      .rsp_out_length         (rsp_out_length),
      .rsp_responded          (rsp_responded),
      .rsp_out_data           (rsp_out_data),
      .rsp_last               (rsp_last)
   );

`ifndef NO_ASSERTIONS
   // an idle bus never leaves a queued request waiting once the beat is done
   a_idle_bus_empty_queue: assert property (@(posedge clock) disable iff (reset)
      (!busy && status.phase == fba_pkg::PH_IDLE) |-> !status.nonempty)
      else $error("idle bus with queued request");

   // a slave request is always the final result of its beat
   a_grant_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == fba_pkg::EV_SREQ) |-> rsp_last)
      else $error("slave request not marked last");

   // a dropped request carries only its master id
   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == fba_pkg::EV_DROP) |->
      (rsp_last && rsp_out_address == 32'd0 && rsp_out_length == 8'd0))
      else $error("dropped request result malformed");

   // a taken beat always keeps the block busy for the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("beat taken without going busy");
`endif

endmodule

// File: rtl/fba_ram.sv
// generic single-port-write, registered-read ram
// no dependencies

module fba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/fba_ctrl.sv
// sequencing state machine of the arbiter: one beat at a time, at most one result per cycle
// depends on fba_pkg

module fba_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  fba_pkg::fba_status_type status,
   output logic                    busy,
   output fba_pkg::fba_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_EXEC  = 5'b00010,
      ST_END   = 5'b00100,
      ST_READ  = 5'b01000,
      ST_GRANT = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            case (status.kind)
               fba_pkg::KIND_REQ: begin
                  if (status.full) begin
                     cmd.emit = 1'b1;
                     cmd.ev   = fba_pkg::EV_DROP;
                     cmd.last = 1'b1;
                  end else begin
                     cmd.push = 1'b1;
                     if (status.phase == fba_pkg::PH_IDLE) begin
                        state_in = ST_READ;
                     end
                  end
               end
               fba_pkg::KIND_ACK: begin
                  cmd.ack_seen = (status.phase == fba_pkg::PH_WAIT);
               end
               fba_pkg::KIND_DATA: begin
                  if (status.phase == fba_pkg::PH_XFER) begin
                     cmd.emit      = 1'b1;
                     cmd.ev        = fba_pkg::EV_DATA;
                     cmd.word_step = 1'b1;
                     cmd.last      = !status.word_end;
                     if (status.word_end) begin
                        state_in = ST_END;
                     end
                  end
               end
               fba_pkg::KIND_TICK: begin
                  if (status.phase == fba_pkg::PH_WAIT) begin
                     cmd.tick_wait = 1'b1;
                  end else if (status.phase == fba_pkg::PH_REPORT) begin
                     cmd.emit        = 1'b1;
                     cmd.ev          = fba_pkg::EV_MACK;
                     cmd.report_done = 1'b1;
                     cmd.last        = status.responded || !status.nonempty;
                     if (!status.responded && status.nonempty) begin
                        state_in = ST_READ;
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_END: begin
            cmd.emit     = 1'b1;
            cmd.ev       = fba_pkg::EV_END;
            cmd.bus_free = 1'b1;
            cmd.last     = !status.nonempty;
            state_in     = status.nonempty ? ST_READ : ST_IDLE;
         end
         ST_READ: begin
            cmd.head_read = 1'b1;
            state_in      = ST_GRANT;
         end
         ST_GRANT: begin
            cmd.grant = 1'b1;
            cmd.emit  = 1'b1;
            cmd.ev    = fba_pkg::EV_SREQ;
            cmd.last  = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// File: rtl/fba_dp.sv
// arbiter datapath: request queue, current request, bus phase, counters, result register
// depends on fba_pkg and fba_ram

module fba_dp #(
   parameter int QUEUE_DEPTH = fba_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [1:0]              req_kind,
   input  logic [3:0]              req_master_id,
   input  logic                    req_read_not_write,
   input  logic [31:0]             req_address,
   input  logic [7:0]              req_length,
   input  logic [31:0]             req_word_data,
   input  logic                    csr_we,
   input  logic [3:0]              csr_wdata,
   input  fba_pkg::fba_cmd_type    cmd,
   output fba_pkg::fba_status_type status,
   output logic                    rsp_valid,
   output logic [2:0]              rsp_event_res,
   output logic [3:0]              rsp_out_master_id,
   output logic                    rsp_out_read_not_write,
   output logic [31:0]             rsp_out_address,
   output logic [7:0]              rsp_out_length,
   output logic                    rsp_responded,
   output logic [31:0]             rsp_out_data,
   output logic                    rsp_last
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   // captured beat
   fba_pkg::fba_kind_type item_kind_ff;
   fba_pkg::fba_req_type  item_ff;
   logic [31:0]           item_data_ff;

   // arbiter state
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [PTR_W-1:0]       head_ff, head_in;
   logic [PTR_W-1:0]       tail_ff, tail_in;
   fba_pkg::fba_phase_type phase_ff, phase_in;
   logic [3:0]             wait_ff, wait_in;
   logic                   responded_ff, responded_in;
   logic [7:0]             words_ff, words_in;
   logic [3:0]             timeout_ff;
   fba_pkg::fba_req_type   current_ff, current_in;

   // result register
   logic                  rsp_valid_ff;
   fba_pkg::fba_event_type rsp_event_ff;
   fba_pkg::fba_req_type  rsp_req_ff, rsp_req_in;
   logic                  rsp_responded_ff;
   logic [31:0]           rsp_data_ff;
   logic                  rsp_last_ff;

   logic [fba_pkg::REQ_W-1:0] ram_rdata;
   fba_pkg::fba_req_type      head_req;
   logic [3:0]                limit;
   logic [3:0]                wait_inc;
   logic [7:0]                words_inc;

   fba_ram #(
      .WIDTH (fba_pkg::REQ_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .wr_en   (cmd.push),
      .wr_addr (tail_ff),
      .wr_data (item_ff),
      .rd_en   (cmd.head_read),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   assign head_req  = fba_pkg::fba_req_type'(ram_rdata);
   assign limit     = (timeout_ff == 4'd0) ? 4'd1 : timeout_ff;
   assign wait_inc  = wait_ff + 4'd1;
   assign words_inc = words_ff + 8'd1;

   always_comb begin
      count_in     = count_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      phase_in     = phase_ff;
      wait_in      = wait_ff;
      responded_in = responded_ff;
      words_in     = words_ff;
      current_in   = current_ff;
      if (cmd.push) begin
         count_in = count_ff + CNT_W'(1);
         tail_in  = (tail_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
      end
      if (cmd.grant) begin
         count_in     = count_ff - CNT_W'(1);
         head_in      = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         phase_in     = fba_pkg::PH_WAIT;
         wait_in      = 4'd0;
         responded_in = 1'b0;
         words_in     = 8'd0;
         current_in   = head_req;
      end
      if (cmd.ack_seen) begin
         responded_in = 1'b1;
         phase_in     = fba_pkg::PH_REPORT;
      end
      if (cmd.tick_wait) begin
         wait_in = wait_inc;
         if (wait_inc >= limit) begin
            phase_in = fba_pkg::PH_REPORT;
         end
      end
      if (cmd.word_step) begin
         words_in = words_inc;
      end
      if (cmd.report_done) begin
         if (responded_ff) begin
            phase_in = fba_pkg::PH_XFER;
            words_in = 8'd0;
         end else begin
            phase_in = fba_pkg::PH_IDLE;
         end
      end
      if (cmd.bus_free) begin
         phase_in = fba_pkg::PH_IDLE;
      end
   end

   // result payload selection
   always_comb begin
      case (cmd.ev)
         fba_pkg::EV_SREQ: begin
            rsp_req_in = head_req;
         end
         fba_pkg::EV_DROP: begin
            rsp_req_in           = '0;
            rsp_req_in.master_id = item_ff.master_id;
         end
         default: begin
            rsp_req_in = current_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         head_ff      <= '0;
         tail_ff      <= '0;
         phase_ff     <= fba_pkg::PH_IDLE;
         wait_ff      <= 4'd0;
         responded_ff <= 1'b0;
         words_ff     <= 8'd0;
         timeout_ff   <= fba_pkg::TIMEOUT_RESET;
         current_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         phase_ff     <= phase_in;
         wait_ff      <= wait_in;
         responded_ff <= responded_in;
         words_ff     <= words_in;
         if (csr_we) begin
            timeout_ff <= csr_wdata;
         end
         current_ff   <= current_in;
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_kind_ff             <= fba_pkg::fba_kind_type'(req_kind);
         item_ff.master_id        <= req_master_id;
         item_ff.read_not_write   <= req_read_not_write;
         item_ff.address          <= req_address;
         item_ff.length           <= req_length;
         item_data_ff             <= req_word_data;
      end
      if (cmd.emit) begin
         rsp_event_ff     <= cmd.ev;
         rsp_req_ff       <= rsp_req_in;
         rsp_responded_ff <= (cmd.ev == fba_pkg::EV_MACK) ? responded_ff : 1'b0;
         rsp_data_ff      <= (cmd.ev == fba_pkg::EV_DATA) ? item_data_ff : 32'd0;
         rsp_last_ff      <= cmd.last;
      end
   end

   assign status.kind      = item_kind_ff;
   assign status.phase     = phase_ff;
   assign status.full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.nonempty  = (count_ff != '0);
   assign status.word_end  = (words_inc == current_ff.length);
   assign status.responded = responded_ff;

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_event_res          = rsp_event_ff;
   assign rsp_out_master_id      = rsp_req_ff.master_id;
   assign rsp_out_read_not_write = rsp_req_ff.read_not_write;
   assign rsp_out_address        = rsp_req_ff.address;
   assign rsp_out_length         = rsp_req_ff.length;
   assign rsp_responded          = rsp_responded_ff;
   assign rsp_out_data           = rsp_data_ff;
   assign rsp_last               = rsp_last_ff;

endmodule
